[rtl/core/lrmb_pkg.sv]
// Shared types and constants for the linear regression gradient step core.
// Used by the controller, datapath and top level.
`default_nettype none
package lrmb_pkg;

	localparam int MAX_FEATURES = 8;
	localparam int IDX_W = $clog2(MAX_FEATURES);
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIMENSION = 1'b0,
		REG_STEP_SIZE = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_TRAIN = 2'd0,
		OP_LOSS  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_H_MUL,
		CMD_H_ACC,
		CMD_ERR,
		CMD_G_MUL,
		CMD_G_ACC,
		CMD_L_MUL,
		CMD_L_ACC,
		CMD_U_LO,
		CMD_U_HI,
		CMD_U_ACC,
		CMD_GRAD_CLR,
		CMD_EMIT_W,
		CMD_EMIT_L,
		CMD_CLR_W
	} cmd_t;

	typedef struct packed {
		logic             take;
		cmd_t             cmd;
		logic [IDX_W-1:0] idx;
		logic             last;
	} ctl_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic [1:0]          opcode;
		logic signed [15:0]  x0;
		logic signed [15:0]  x1;
		logic signed [15:0]  x2;
		logic signed [15:0]  x3;
		logic signed [15:0]  x4;
		logic signed [15:0]  x5;
		logic signed [15:0]  x6;
		logic signed [15:0]  x7;
		logic signed [15:0]  target;
		logic                last_in_batch;
	} sample_t;

endpackage
`default_nettype wire

[rtl/core/lrmb_sample_if.sv]
// Input channel: one training, loss, read or clear word per handshake.
// Depends on nothing.
`default_nettype none
interface lrmb_sample_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic signed [15:0] x0;
	logic signed [15:0] x1;
	logic signed [15:0] x2;
	logic signed [15:0] x3;
	logic signed [15:0] x4;
	logic signed [15:0] x5;
	logic signed [15:0] x6;
	logic signed [15:0] x7;
	logic signed [15:0] target;
	logic               last_in_batch;

	modport source (output valid, opcode, x0, x1, x2, x3, x4, x5, x6, x7, target,
		last_in_batch, input ready);
	modport sink (input valid, opcode, x0, x1, x2, x3, x4, x5, x6, x7, target,
		last_in_batch, output ready);
endinterface

// Output channel: one theta element or loss total per handshake.
interface lrmb_result_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [2:0]         index;
	logic signed [47:0] value;
	logic               last;

	modport source (output valid, kind, index, value, last, input ready);
	modport sink (input valid, kind, index, value, last, output ready);
endinterface
`default_nettype wire

[rtl/core/linreg_minibatch_gradient_step_core.sv]
// Linear regression minibatch gradient step core.
// Channels: sample (sink) takes one word per item: opcode, eight signed Q8.8
// features, Q8.8 target, last_in_batch. result (source) gives theta elements
// (kind 0) or the loss total (kind 1), last set on the final word of an item.
// Configuration: cfg_we/cfg_index/cfg_data write dimension (0) or
// step size (1); write only while the core is idle.
// The sequencer shares one multiply step per cycle and walks the features in
// use one at a time. train: hypothesis multiply and accumulate per feature,
// error, then gradient multiply and accumulate per feature; at batch end, per
// feature low and high step partial products and theta update, then gradient
// clear. loss: hypothesis and error, then square and accumulate; at pass end
// one output word is loaded. read: one theta word per cycle while result is
// taken. clear: theta is zeroed.
// Results go through a one-word output register; a stalled receiver holds the
// sequencer while a new word waits to be loaded. The next item is taken the
// cycle after the last word of the current one is loaded.
// Reset clears theta, gradient and loss sums, sets dimension 8 and
// step size 655.
// Depends on lrmb_pkg, lrmb_sample_if, lrmb_result_if, lrmb_ctrl, lrmb_dp.
`default_nettype none
module linreg_minibatch_gradient_step_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [lrmb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [lrmb_pkg::CFG_DATA_W-1:0]    cfg_data,
	lrmb_sample_if.sink                             sample,
	lrmb_result_if.source                           result
);

	logic [3:0]                  dim_q;
	logic [15:0]                 lr_q;
	logic [lrmb_pkg::IDX_W-1:0]  dmax;
	lrmb_pkg::ctl_t              ctl;
	lrmb_pkg::stat_t             stat;
	lrmb_pkg::sample_t           smp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= 4'd8;
			lr_q  <= 16'd655;
		end else if (cfg_we) begin
			unique case (lrmb_pkg::reg_idx_t'(cfg_index))
				lrmb_pkg::REG_DIMENSION: dim_q <= cfg_data[3:0];
				lrmb_pkg::REG_STEP_SIZE: lr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, anything past the feature count as the full count
	always_comb begin
		if (dim_q == 4'd0) dmax = '0;
		else if (dim_q > 4'(lrmb_pkg::MAX_FEATURES)) dmax = '1;
		else dmax = lrmb_pkg::IDX_W'(dim_q - 4'd1);
	end

	assign smp.opcode        = sample.opcode;
	assign smp.x0            = sample.x0;
	assign smp.x1            = sample.x1;
	assign smp.x2            = sample.x2;
	assign smp.x3            = sample.x3;
	assign smp.x4            = sample.x4;
	assign smp.x5            = sample.x5;
	assign smp.x6            = sample.x6;
	assign smp.x7            = sample.x7;
	assign smp.target        = sample.target;
	assign smp.last_in_batch = sample.last_in_batch;

	lrmb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_opcode (smp.opcode),
		.in_last   (smp.last_in_batch),
		.dmax      (dmax),
		.stat      (stat),
		.in_ready  (sample.ready),
		.ctl       (ctl)
	);

	lrmb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.smp        (smp),
		.step_size  (lr_q),
		.res_ready  (result.ready),
		.stat       (stat),
		.res_valid  (result.valid),
		.res_kind   (result.kind),
		.res_index  (result.index),
		.res_value  (result.value),
		.res_last   (result.last)
	);

endmodule
`default_nettype wire

[rtl/core/lrmb_ctrl.sv]
// Sequencer for the gradient step core: walks features one at a time and
// issues datapath commands. Depends on lrmb_pkg.
`default_nettype none
module lrmb_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic [1:0]               in_opcode,
	input  wire logic                     in_last,
	input  wire logic [lrmb_pkg::IDX_W-1:0] dmax,
	input  wire lrmb_pkg::stat_t          stat,
	output logic                          in_ready,
	output lrmb_pkg::ctl_t                ctl
);

	typedef enum logic [3:0] {
		S_IDLE, S_H_MUL, S_H_ACC, S_ERR, S_G_MUL, S_G_ACC, S_L_MUL, S_L_ACC,
		S_U_LO, S_U_HI, S_U_ACC, S_GCLR, S_EMIT_W, S_EMIT_L, S_CLR
	} state_t;

	state_t                      state_q;
	logic [lrmb_pkg::IDX_W-1:0]  idx_q;
	lrmb_pkg::op_t               op_q;
	logic                        last_q;
	logic                        at_end;

	assign in_ready = (state_q == S_IDLE);
	assign at_end   = (idx_q == dmax);

	always_comb begin
		ctl.take = in_valid && in_ready;
		ctl.idx  = idx_q;
		ctl.last = at_end;
		unique case (state_q)
			S_H_MUL:  ctl.cmd = lrmb_pkg::CMD_H_MUL;
			S_H_ACC:  ctl.cmd = lrmb_pkg::CMD_H_ACC;
			S_ERR:    ctl.cmd = lrmb_pkg::CMD_ERR;
			S_G_MUL:  ctl.cmd = lrmb_pkg::CMD_G_MUL;
			S_G_ACC:  ctl.cmd = lrmb_pkg::CMD_G_ACC;
			S_L_MUL:  ctl.cmd = lrmb_pkg::CMD_L_MUL;
			S_L_ACC:  ctl.cmd = lrmb_pkg::CMD_L_ACC;
			S_U_LO:   ctl.cmd = lrmb_pkg::CMD_U_LO;
			S_U_HI:   ctl.cmd = lrmb_pkg::CMD_U_HI;
			S_U_ACC:  ctl.cmd = lrmb_pkg::CMD_U_ACC;
			S_GCLR:   ctl.cmd = lrmb_pkg::CMD_GRAD_CLR;
			S_CLR:    ctl.cmd = lrmb_pkg::CMD_CLR_W;
			S_EMIT_W: ctl.cmd = stat.out_free ? lrmb_pkg::CMD_EMIT_W : lrmb_pkg::CMD_NONE;
			S_EMIT_L: ctl.cmd = stat.out_free ? lrmb_pkg::CMD_EMIT_L : lrmb_pkg::CMD_NONE;
			default:  ctl.cmd = lrmb_pkg::CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			op_q    <= lrmb_pkg::OP_TRAIN;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ctl.take) begin
						op_q   <= lrmb_pkg::op_t'(in_opcode);
						last_q <= in_last;
						idx_q  <= '0;
						unique case (lrmb_pkg::op_t'(in_opcode))
							lrmb_pkg::OP_READ:  state_q <= S_EMIT_W;
							lrmb_pkg::OP_CLEAR: state_q <= S_CLR;
							default:            state_q <= S_H_MUL;
						endcase
					end
				end
				S_H_MUL: state_q <= S_H_ACC;
				S_H_ACC: begin
					if (at_end) begin
						state_q <= S_ERR;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_H_MUL;
					end
				end
				S_ERR: begin
					idx_q   <= '0;
					state_q <= (op_q == lrmb_pkg::OP_TRAIN) ? S_G_MUL : S_L_MUL;
				end
				S_G_MUL: state_q <= S_G_ACC;
				S_G_ACC: begin
					if (!at_end) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_G_MUL;
					end else if (last_q) begin
						idx_q   <= '0;
						state_q <= S_U_LO;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_U_LO: state_q <= S_U_HI;
				S_U_HI: state_q <= S_U_ACC;
				S_U_ACC: begin
					if (at_end) begin
						state_q <= S_GCLR;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_U_LO;
					end
				end
				S_GCLR:  state_q <= S_IDLE;
				S_L_MUL: state_q <= S_L_ACC;
				S_L_ACC: state_q <= last_q ? S_EMIT_L : S_IDLE;
				S_EMIT_L: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				S_EMIT_W: begin
					if (stat.out_free) begin
						if (at_end) state_q <= S_IDLE;
						else idx_q <= idx_q + 1'b1;
					end
				end
				S_CLR:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/lrmb_dp.sv]
// Datapath: theta, gradient and loss registers, one shared multiply step per
// command, and the result output register. Depends on lrmb_pkg.
`default_nettype none
module lrmb_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lrmb_pkg::ctl_t     ctl,
	input  wire lrmb_pkg::sample_t  smp,
	input  wire logic [15:0]        step_size,
	input  wire logic               res_ready,
	output lrmb_pkg::stat_t         stat,
	output logic                    res_valid,
	output logic                    res_kind,
	output logic [2:0]              res_index,
	output logic signed [47:0]      res_value,
	output logic                    res_last
);

	localparam int NF = lrmb_pkg::MAX_FEATURES;

	logic signed [31:0] w_q    [NF];
	logic signed [47:0] grad_q [NF];
	logic signed [15:0] x_q    [NF];
	logic signed [15:0] y_q;
	logic signed [47:0] loss_q;
	logic signed [50:0] acc_q;
	logic signed [31:0] err_q;
	logic signed [63:0] prod_q;
	logic [39:0]        lo_q;
	logic               valid_q;

	logic signed [31:0] w_sel;
	logic signed [15:0] x_sel;
	logic signed [47:0] g_sel;
	logic signed [47:0] mul_h;
	logic signed [47:0] mul_g;
	logic signed [63:0] mul_l;
	logic [39:0]        mul_lo;
	logic signed [40:0] mul_hi;
	logic signed [47:0] prod_g;
	logic signed [63:0] full_u;
	logic signed [47:0] step_u;
	logic signed [48:0] err_d;
	logic signed [48:0] gsum_d;
	logic signed [48:0] lsum_d;
	logic signed [48:0] wnew_d;
	logic               emit;

	function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
		if (v > 49'sd2147483647) return 32'sh7fffffff;
		if (v < -49'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
		if (v[48] != v[47]) return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		return v[47:0];
	endfunction

	assign w_sel = w_q[ctl.idx];
	assign x_sel = x_q[ctl.idx];
	assign g_sel = grad_q[ctl.idx];

	assign mul_h  = w_sel * x_sel;
	assign mul_g  = err_q * x_sel;
	assign mul_l  = err_q * err_q;
	assign mul_lo = {24'd0, step_size} * {16'd0, g_sel[23:0]};
	assign mul_hi = $signed({1'b0, step_size}) * $signed(g_sel[47:24]);

	assign prod_g = prod_q[47:0];
	// recombine the two step size partial products
	assign full_u = (prod_q <<< 24) + $signed({24'd0, lo_q});
	assign step_u = 48'(full_u >>> 16);
	assign err_d  = 49'(acc_q >>> 8) - (49'(y_q) <<< 8);
	assign gsum_d = 49'(g_sel) + 49'(prod_g >>> 8);
	assign lsum_d = 49'(loss_q) + 49'(prod_q >>> 17);
	assign wnew_d = 49'(w_sel) - 49'(step_u);

	assign emit = (ctl.cmd == lrmb_pkg::CMD_EMIT_W) || (ctl.cmd == lrmb_pkg::CMD_EMIT_L);

	assign stat.out_free = !valid_q || res_ready;
	assign res_valid     = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NF; i++) begin
				w_q[i]    <= '0;
				grad_q[i] <= '0;
			end
			loss_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (emit) valid_q <= 1'b1;
			else if (res_ready) valid_q <= 1'b0;
			case (ctl.cmd)
				lrmb_pkg::CMD_G_ACC:  grad_q[ctl.idx] <= sat48(gsum_d);
				lrmb_pkg::CMD_L_ACC:  loss_q <= sat48(lsum_d);
				lrmb_pkg::CMD_U_ACC:  w_q[ctl.idx] <= sat32(wnew_d);
				lrmb_pkg::CMD_GRAD_CLR: begin
					for (int i = 0; i < NF; i++) grad_q[i] <= '0;
				end
				lrmb_pkg::CMD_CLR_W: begin
					for (int i = 0; i < NF; i++) w_q[i] <= '0;
				end
				lrmb_pkg::CMD_EMIT_L: loss_q <= '0;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			x_q[0] <= smp.x0;
			x_q[1] <= smp.x1;
			x_q[2] <= smp.x2;
			x_q[3] <= smp.x3;
			x_q[4] <= smp.x4;
			x_q[5] <= smp.x5;
			x_q[6] <= smp.x6;
			x_q[7] <= smp.x7;
			y_q    <= smp.target;
			acc_q  <= '0;
		end
		case (ctl.cmd)
			lrmb_pkg::CMD_H_MUL: prod_q <= 64'(mul_h);
			lrmb_pkg::CMD_H_ACC: acc_q  <= acc_q + 51'($signed(prod_q[47:0]));
			lrmb_pkg::CMD_ERR:   err_q  <= sat32(err_d);
			lrmb_pkg::CMD_G_MUL: prod_q <= 64'(mul_g);
			lrmb_pkg::CMD_L_MUL: prod_q <= mul_l;
			lrmb_pkg::CMD_U_LO:  lo_q   <= mul_lo;
			lrmb_pkg::CMD_U_HI:  prod_q <= 64'(mul_hi);
			lrmb_pkg::CMD_EMIT_W: begin
				res_kind  <= 1'b0;
				res_index <= 3'(ctl.idx);
				res_value <= 48'(w_sel);
				res_last  <= ctl.last;
			end
			lrmb_pkg::CMD_EMIT_L: begin
				res_kind  <= 1'b1;
				res_index <= '0;
				res_value <= loss_q;
				res_last  <= 1'b1;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[bench/tb.sv]
// Testbench for linreg_minibatch_gradient_step_core: random and directed samples,
// with a self-contained fixed-point predictor and in-order result checking.
// Depends on lrmb_pkg, lrmb_sample_if, lrmb_result_if and the core RTL.
`timescale 1ns / 1ps
module tb;

	typedef logic signed [15:0] feats_t [lrmb_pkg::MAX_FEATURES];

	typedef struct {
		logic               kind;
		logic [2:0]         index;
		logic signed [47:0] value;
		logic               last;
	} result_word_t;

	localparam int DRAIN_CYCLES = 80;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [lrmb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lrmb_pkg::CFG_DATA_W-1:0] cfg_data;

	lrmb_sample_if sample ();
	lrmb_result_if result ();

	linreg_minibatch_gradient_step_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(sample),
		.result(result)
	);

	// predictor state
	logic signed [31:0] theta [lrmb_pkg::MAX_FEATURES];
	longint grad_sum [lrmb_pkg::MAX_FEATURES];
	longint loss_total;
	int dim_reg;
	int rate_reg;

	result_word_t expected_words [$];
	int sender_idle;
	int receiver_idle;
	int mismatches;
	int items_sent;
	int words_seen;
	int reads_sent;
	int losses_sent;
	int batches_done;
	logic holding;
	event hold_ev;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic longint clamp(longint v, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic int used_features();
		if (dim_reg == 0) return 1;
		if (dim_reg > lrmb_pkg::MAX_FEATURES) return lrmb_pkg::MAX_FEATURES;
		return dim_reg;
	endfunction

	// Advance the predictor by one accepted sample and queue the words it causes.
	task automatic model_sample(lrmb_pkg::op_t op, feats_t xs, logic signed [15:0] y,
			logic lb);
		int d;
		longint h;
		longint err;
		longint stp;
		result_word_t w;
		d = used_features();
		h = 0;
		case (op)
			lrmb_pkg::OP_READ: begin
				for (int i = 0; i < d; i++) begin
					w.kind = 1'b0;
					w.index = i[2:0];
					w.value = 48'(longint'(theta[i]));
					w.last = (i == d - 1);
					expected_words.push_back(w);
				end
				reads_sent++;
			end
			lrmb_pkg::OP_CLEAR: begin
				for (int i = 0; i < lrmb_pkg::MAX_FEATURES; i++) theta[i] = '0;
			end
			default: begin
				for (int i = 0; i < d; i++) h += longint'(theta[i]) * longint'(xs[i]);
				err = clamp((h >>> 8) - longint'(y) * 256, 32);
				if (op == lrmb_pkg::OP_TRAIN) begin
					for (int i = 0; i < d; i++)
						grad_sum[i] = clamp(grad_sum[i] + ((err * longint'(xs[i])) >>> 8), 48);
					if (lb) begin
						for (int i = 0; i < d; i++) begin
							stp = (longint'(rate_reg) * grad_sum[i]) >>> 16;
							theta[i] = 32'(clamp(longint'(theta[i]) - stp, 32));
						end
						for (int i = 0; i < lrmb_pkg::MAX_FEATURES; i++) grad_sum[i] = 0;
						batches_done++;
					end
				end else begin
					loss_total = clamp(loss_total + ((err * err) >>> 17), 48);
					if (lb) begin
						w.kind = 1'b1;
						w.index = '0;
						w.value = 48'(loss_total);
						w.last = 1'b1;
						expected_words.push_back(w);
						loss_total = 0;
						losses_sent++;
					end
				end
			end
		endcase
	endtask

	task automatic send_sample(lrmb_pkg::op_t op, feats_t xs, logic signed [15:0] y,
			logic lb);
		while ($urandom_range(99) < sender_idle) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.opcode <= op;
		sample.x0 <= xs[0];
		sample.x1 <= xs[1];
		sample.x2 <= xs[2];
		sample.x3 <= xs[3];
		sample.x4 <= xs[4];
		sample.x5 <= xs[5];
		sample.x6 <= xs[6];
		sample.x7 <= xs[7];
		sample.target <= y;
		sample.last_in_batch <= lb;
		do @(posedge clk); while (!sample.ready);
		model_sample(op, xs, y, lb);
		items_sent++;
	endtask

	// Drop valid, wait for all words, then let the sequencer finish silent work.
	task automatic drain();
		int guard;
		guard = 0;
		sample.valid <= 1'b0;
		while (expected_words.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(int dim, int rate);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= lrmb_pkg::REG_DIMENSION;
		cfg_data <= 16'(dim);
		@(posedge clk);
		cfg_index <= lrmb_pkg::REG_STEP_SIZE;
		cfg_data <= 16'(rate);
		@(posedge clk);
		cfg_we <= 1'b0;
		dim_reg = dim & 15;
		rate_reg = rate & 16'hffff;
	endtask

	function automatic logic signed [15:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 70) return 16'($signed($urandom_range(2048)) - 1024);
		if (r < 85) return 16'($urandom);
		case ($urandom_range(3))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return 16'shffff;
		endcase
	endfunction

	function automatic feats_t pick_feats();
		feats_t xs;
		for (int i = 0; i < lrmb_pkg::MAX_FEATURES; i++) xs[i] = pick_value();
		return xs;
	endfunction

	function automatic feats_t fill_feats(logic signed [15:0] v);
		feats_t xs;
		for (int i = 0; i < lrmb_pkg::MAX_FEATURES; i++) xs[i] = v;
		return xs;
	endfunction

	task automatic test_directed();
		feats_t xs;
		send_sample(lrmb_pkg::OP_READ, fill_feats(16'sh0), 16'sh0, 1'b0);
		// every feature at 1.0 (Q8.8) so theta moves
		xs = fill_feats(16'sh0100);
		send_sample(lrmb_pkg::OP_TRAIN, xs, 16'sh0300, 1'b0);
		send_sample(lrmb_pkg::OP_TRAIN, xs, 16'sh0300, 1'b1);
		send_sample(lrmb_pkg::OP_READ, xs, 16'sh0, 1'b1);
		send_sample(lrmb_pkg::OP_TRAIN, fill_feats(16'sh7fff), 16'sh8000, 1'b1);
		send_sample(lrmb_pkg::OP_TRAIN, fill_feats(16'sh8000), 16'sh7fff, 1'b1);
		send_sample(lrmb_pkg::OP_READ, xs, 16'sh0, 1'b0);
		send_sample(lrmb_pkg::OP_LOSS, fill_feats(16'sh7fff), 16'sh8000, 1'b0);
		send_sample(lrmb_pkg::OP_LOSS, fill_feats(16'sh8000), 16'sh7fff, 1'b1);
		send_sample(lrmb_pkg::OP_LOSS, xs, 16'sh0100, 1'b1);
		send_sample(lrmb_pkg::OP_CLEAR, xs, 16'sh0, 1'b1);
		send_sample(lrmb_pkg::OP_READ, xs, 16'sh0, 1'b0);
		send_sample(lrmb_pkg::OP_TRAIN, fill_feats(16'shffff), 16'sh0001, 1'b0);
		send_sample(lrmb_pkg::OP_CLEAR, xs, 16'sh0, 1'b0);
		send_sample(lrmb_pkg::OP_TRAIN, fill_feats(16'sh0001), 16'shffff, 1'b1);
		send_sample(lrmb_pkg::OP_READ, xs, 16'sh0, 1'b1);
	endtask

	task automatic test_dimension_edges();
		feats_t xs;
		xs = fill_feats(16'sh0200);
		set_config(0, 16'hffff);
		send_sample(lrmb_pkg::OP_TRAIN, xs, 16'sh0400, 1'b1);
		send_sample(lrmb_pkg::OP_READ, xs, 16'sh0, 1'b0);
		send_sample(lrmb_pkg::OP_LOSS, xs, 16'sh0100, 1'b1);
		set_config(15, 0);
		send_sample(lrmb_pkg::OP_TRAIN, xs, 16'sh0400, 1'b1);
		send_sample(lrmb_pkg::OP_READ, xs, 16'sh0, 1'b0);
		set_config(1, 1);
		send_sample(lrmb_pkg::OP_READ, xs, 16'sh0, 1'b0);
	endtask

	task automatic test_random(int n);
		int cnt;
		int len;
		int r;
		cnt = 0;
		while (cnt < n) begin
			r = $urandom_range(99);
			if (r < 55) begin
				len = $urandom_range(5, 1);
				for (int k = 0; k < len; k++)
					send_sample(lrmb_pkg::OP_TRAIN, pick_feats(), pick_value(),
						k == len - 1);
			end else if (r < 75) begin
				len = $urandom_range(4, 1);
				for (int k = 0; k < len; k++)
					send_sample(lrmb_pkg::OP_LOSS, pick_feats(), pick_value(),
						k == len - 1);
			end else if (r < 87) begin
				len = 1;
				send_sample(lrmb_pkg::OP_READ, pick_feats(), pick_value(), 1'($urandom));
			end else if (r < 92) begin
				len = 1;
				send_sample(lrmb_pkg::OP_CLEAR, pick_feats(), pick_value(), 1'($urandom));
			end else begin
				len = 1;
				send_sample(lrmb_pkg::op_t'($urandom_range(3)), pick_feats(), pick_value(),
					1'($urandom));
			end
			cnt += len;
		end
	endtask

	// Hold the receiver while reads pile up, so the input stalls.
	task automatic test_backpressure();
		-> hold_ev;
		repeat (10) send_sample(lrmb_pkg::OP_READ, pick_feats(), pick_value(), 1'b0);
		send_sample(lrmb_pkg::OP_TRAIN, pick_feats(), pick_value(), 1'b1);
		send_sample(lrmb_pkg::OP_LOSS, pick_feats(), pick_value(), 1'b1);
	endtask

	initial begin
		holding = 1'b0;
		forever begin
			@(hold_ev);
			holding <= 1'b1;
			repeat (400) @(posedge clk);
			holding <= 1'b0;
		end
	end

	initial result.ready = 1'b0;
	always @(posedge clk)
		result.ready <= !holding && ($urandom_range(99) >= receiver_idle);

	always @(posedge clk) begin
		result_word_t w;
		if (arst_n && result.valid && result.ready) begin
			words_seen++;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: kind %0d index %0d value %0d last %0d",
						result.kind, result.index, result.value, result.last);
			end else begin
				w = expected_words.pop_front();
				if (w.kind !== result.kind || w.index !== result.index ||
						w.value !== result.value || w.last !== result.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp kind %0d index %0d value %0d last %0d,",
							" got %0d %0d %0d %0d"},
							w.kind, w.index, w.value, w.last,
							result.kind, result.index, result.value, result.last);
				end
			end
		end
	end

	initial begin
		int guard;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample.valid = 1'b0;
		sample.opcode = lrmb_pkg::OP_TRAIN;
		sample.x0 = '0;
		sample.x1 = '0;
		sample.x2 = '0;
		sample.x3 = '0;
		sample.x4 = '0;
		sample.x5 = '0;
		sample.x6 = '0;
		sample.x7 = '0;
		sample.target = '0;
		sample.last_in_batch = 1'b0;
		for (int i = 0; i < lrmb_pkg::MAX_FEATURES; i++) begin
			theta[i] = '0;
			grad_sum[i] = 0;
		end
		loss_total = 0;
		dim_reg = 8;
		rate_reg = 655;
		mismatches = 0;
		items_sent = 0;
		words_seen = 0;
		reads_sent = 0;
		losses_sent = 0;
		batches_done = 0;
		sender_idle = 26;
		receiver_idle = 52;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_dimension_edges();
		set_config(8, 655);
		test_random(25);
		test_backpressure();

		sender_idle = 52;
		receiver_idle = 26;
		set_config($urandom_range(8, 1), 16'hffff);
		test_random(25);

		sender_idle = 0;
		receiver_idle = 0;
		set_config($urandom_range(8, 1), $urandom_range(65535));
		test_random(25);
		test_backpressure();

		sample.valid <= 1'b0;
		guard = 0;
		while (expected_words.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d samples (%0d batch ends, %0d loss totals, %0d reads), %0d words",
			items_sent, batches_done, losses_sent, reads_sent, words_seen);
		$display("dimension 0..15 and step size 0..65535 exercised; %0d mismatches",
			mismatches);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

[linreg_minibatch_gradient_step_core.f]
rtl/core/lrmb_pkg.sv
rtl/core/lrmb_sample_if.sv
rtl/core/lrmb_ctrl.sv
rtl/core/lrmb_dp.sv
rtl/core/linreg_minibatch_gradient_step_core.sv
bench/tb.sv
